// File: sv/dsd_pkg.sv
// Shared types, constants and the segment table of the duty setpoint display core.
`default_nettype none

package dsd_pkg;

  // Display geometry
  localparam int unsigned DIGIT_COUNT = 3;

  // Reset values and limits
  localparam logic [6:0]  DUTY_RESET  = 7'd50;
  localparam logic [6:0]  DUTY_MAX    = 7'd100;
  localparam logic [15:0] TOP_RESET   = 16'd1249;
  localparam logic [9:0]  BLANK_RESET = 10'd720;
  localparam logic [7:0]  DOT_BIT     = 8'h80;

  // ADC scaling: sample * 500 / 1024
  localparam logic [8:0]  ADC_SCALE   = 9'd500;
  localparam int unsigned ADC_SHIFT   = 10;

  // Divide by 100 through reciprocal: ceil(2^30 / 100), exact for products below 2^23
  localparam logic [23:0] RECIP_100   = 24'd10737419;
  localparam int unsigned RECIP_SHIFT = 30;

  // Register byte addresses
  localparam logic [2:0]  ADDR_PWM_TOP     = 3'd0;
  localparam logic [2:0]  ADDR_BLANK_TICKS = 3'd4;

  // Commands
  typedef enum logic [1:0] {
    CMD_INC  = 2'd0,
    CMD_DEC  = 2'd1,
    CMD_ADC  = 2'd2,
    CMD_TICK = 2'd3
  } cmd_e;

  // What the display shows: a value up to 499, an optional dot, or nothing
  typedef struct packed {
    logic [8:0] val;
    logic       dot;
    logic       blank;
  } disp_t;

  // Seven-segment pattern of one decimal digit, segments a..g in bits 0..6
  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] pat;
    unique case (digit)
      4'd0:    pat = 8'h3F;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5B;
      4'd3:    pat = 8'h4F;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6D;
      4'd6:    pat = 8'h7D;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7F;
      4'd9:    pat = 8'h6F;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

// File: sv/dsd_seg_decode.sv
// Splits the display value into three digits and picks the segment pattern of one.
`default_nettype none

module dsd_seg_decode (
  input  var dsd_pkg::disp_t disp_i,
  input  wire logic [1:0]    pos_i,
  output logic [7:0]         pattern_o
);

  logic [14:0] hi_prod;
  logic [16:0] q10_prod;
  logic [3:0]  hi;
  logic [5:0]  q10;
  logic [5:0]  hi_x10;
  logic [8:0]  q10_x10;
  logic [3:0]  tens;
  logic [3:0]  ones;
  logic [7:0]  pat0;
  logic [7:0]  pat1;
  logic [7:0]  pat2;

  // val/100 and val/10 by reciprocal, exact for every 9-bit value
  assign hi_prod  = 15'(disp_i.val) * 15'd41;
  assign q10_prod = 17'(disp_i.val) * 17'd205;
  assign hi       = {1'b0, hi_prod[14:12]};
  assign q10      = q10_prod[16:11];
  assign hi_x10   = 6'(hi) * 6'd10;
  assign q10_x10  = 9'(q10) * 9'd10;
  assign tens     = 4'(q10 - hi_x10);
  assign ones     = 4'(disp_i.val - q10_x10);

  // Leading blanks, dot on the leftmost digit
  always_comb begin
    pat0 = (disp_i.val < 9'd100) ? 8'h00 : dsd_pkg::seg_of(hi);
    pat1 = (disp_i.val < 9'd10) ? 8'h00 : dsd_pkg::seg_of(tens);
    pat2 = dsd_pkg::seg_of(ones);
    if (disp_i.dot) begin
      pat0 = pat0 | dsd_pkg::DOT_BIT;
    end
  end

  // Select the scanned digit
  always_comb begin
    if (disp_i.blank) begin
      pattern_o = 8'h00;
    end else begin
      unique case (pos_i)
        2'd0:    pattern_o = pat0;
        2'd1:    pattern_o = pat1;
        2'd2:    pattern_o = pat2;
        default: pattern_o = 8'h00;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/duty_setpoint_seven_segment_display_core.sv
// Duty setpoint keeper with PWM compare value and a scanned three-digit display.
// Path: an accepted input beat is registered in stage 1, then stage 2, then the stage 3
// result register, which presents its result beat on the output.
// Throughput: one beat per cycle while the output is not stalled; three pipeline stages
// with valid bits, each stage moves on when the one after it is empty or being emptied.
// Reset: duty 50, display blank, scan at digit 0, idle count 0, registers at defaults.
`default_nettype none

module duty_setpoint_seven_segment_display_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  // Input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [7:0]  step_amount_i,
  input  wire logic [9:0]  adc_sample_i,

  // Output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [6:0]       duty_percent_o,
  output logic [15:0]      compare_value_o,
  output logic             digit_valid_o,
  output logic [1:0]       digit_index_o,
  output logic [7:0]       segment_pattern_o,

  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Configuration registers
  logic [15:0] pwm_top_q;
  logic [9:0]  blank_ticks_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_top_q     <= dsd_pkg::TOP_RESET;
      blank_ticks_q <= dsd_pkg::BLANK_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == dsd_pkg::ADDR_BLANK_TICKS[2]) begin
        blank_ticks_q <= pwdata[9:0];
      end else begin
        pwm_top_q <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == dsd_pkg::ADDR_BLANK_TICKS[2]) ? {22'd0, blank_ticks_q}
                                                              : {16'd0, pwm_top_q};

  // Pipeline flow control
  logic s1_v_q, s2_v_q, s3_v_q;
  logic adv1, adv2, adv3;
  logic accept;

  assign adv3       = !s3_v_q || !out_stall_i;
  assign adv2       = !s2_v_q || adv3;
  assign adv1       = !s1_v_q || adv2;
  assign in_stall_o = !adv1;
  assign accept     = in_valid_i && adv1;

  // Architectural state
  logic [6:0] duty_q, duty_d;
  logic [9:0] raw_q, raw_d;
  logic       adc_q, adc_d;
  logic       blank_q, blank_d;
  logic [1:0] scan_q, scan_d;
  logic [9:0] idle_q, idle_d;
  logic [1:0] pos_cur;
  logic [2:0] pos_inc;
  logic [8:0] sum;
  logic       is_tick;

  assign sum     = {2'b00, duty_q} + {1'b0, step_amount_i};
  assign pos_cur = (3'(scan_q) >= 3'(dsd_pkg::DIGIT_COUNT)) ? 2'd0 : scan_q;
  assign pos_inc = 3'(pos_cur) + 3'd1;
  assign is_tick = (dsd_pkg::cmd_e'(cmd_i) == dsd_pkg::CMD_TICK);

  // Next state for one accepted beat
  always_comb begin
    duty_d  = duty_q;
    raw_d   = raw_q;
    adc_d   = adc_q;
    blank_d = blank_q;
    scan_d  = scan_q;
    idle_d  = idle_q;
    unique case (dsd_pkg::cmd_e'(cmd_i))
      dsd_pkg::CMD_INC: begin
        duty_d  = (sum > 9'(dsd_pkg::DUTY_MAX)) ? 7'd1 : sum[6:0];
        raw_d   = 10'(duty_d);
        adc_d   = 1'b0;
        blank_d = 1'b0;
        idle_d  = 10'd0;
      end
      dsd_pkg::CMD_DEC: begin
        priority if (step_amount_i == 8'(duty_q)) begin
          duty_d = dsd_pkg::DUTY_MAX;
        end else if (step_amount_i > 8'(duty_q)) begin
          duty_d = 7'd1;
        end else begin
          duty_d = duty_q - step_amount_i[6:0];
        end
        raw_d   = 10'(duty_d);
        adc_d   = 1'b0;
        blank_d = 1'b0;
        idle_d  = 10'd0;
      end
      dsd_pkg::CMD_ADC: begin
        raw_d   = adc_sample_i;
        adc_d   = 1'b1;
        blank_d = 1'b0;
        idle_d  = 10'd0;
      end
      dsd_pkg::CMD_TICK: begin
        scan_d = (pos_inc >= 3'(dsd_pkg::DIGIT_COUNT)) ? 2'd0 : pos_inc[1:0];
        if (idle_q >= blank_ticks_q) begin
          blank_d = 1'b1;
        end else begin
          idle_d = idle_q + 10'd1;
        end
      end
      default: begin
        duty_d = duty_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q  <= dsd_pkg::DUTY_RESET;
      raw_q   <= 10'd0;
      adc_q   <= 1'b0;
      blank_q <= 1'b1;
      scan_q  <= 2'd0;
      idle_q  <= 10'd0;
    end else if (accept) begin
      duty_q  <= duty_d;
      raw_q   <= raw_d;
      adc_q   <= adc_d;
      blank_q <= blank_d;
      scan_q  <= scan_d;
      idle_q  <= idle_d;
    end
  end

  // Stage 1: new setpoint and the display as seen by this beat
  logic [6:0]  s1_duty_q;
  logic [15:0] s1_top_q;
  logic        s1_tick_q;
  logic [1:0]  s1_pos_q;
  logic [9:0]  s1_raw_q;
  logic        s1_adc_q;
  logic        s1_blank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv1) begin
      s1_v_q <= accept;
    end
  end

  // A tick shows the display before its own blanking; updates show their new value
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_duty_q  <= duty_d;
      s1_top_q   <= pwm_top_q;
      s1_tick_q  <= is_tick;
      s1_pos_q   <= pos_cur;
      s1_raw_q   <= is_tick ? raw_q : raw_d;
      s1_adc_q   <= is_tick ? adc_q : adc_d;
      s1_blank_q <= is_tick ? blank_q : blank_d;
    end
  end

  // Stage 2: duty times top, ADC scaling
  logic [6:0]     s2_duty_q;
  logic [22:0]    s2_prod_q;
  logic           s2_tick_q;
  logic [1:0]     s2_pos_q;
  dsd_pkg::disp_t s2_disp_q;
  logic [18:0]    adc_prod;
  logic [8:0]     disp_val;

  assign adc_prod = 19'(s1_raw_q) * 19'(dsd_pkg::ADC_SCALE);
  assign disp_val = s1_adc_q ? adc_prod[18:dsd_pkg::ADC_SHIFT] : s1_raw_q[8:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv2) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && s1_v_q) begin
      s2_duty_q       <= s1_duty_q;
      s2_prod_q       <= 23'(s1_duty_q) * 23'(s1_top_q);
      s2_tick_q       <= s1_tick_q;
      s2_pos_q        <= s1_pos_q;
      s2_disp_q.val   <= disp_val;
      s2_disp_q.dot   <= s1_adc_q;
      s2_disp_q.blank <= s1_blank_q;
    end
  end

  // Stage 3: divide by 100 and segment decode into the result register
  logic [46:0] recip_prod;
  logic [7:0]  pattern;

  assign recip_prod = 47'(s2_prod_q) * 47'(dsd_pkg::RECIP_100);

  dsd_seg_decode u_seg_decode (
    .disp_i    (s2_disp_q),
    .pos_i     (s2_pos_q),
    .pattern_o (pattern)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (adv3) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3 && s2_v_q) begin
      duty_percent_o    <= s2_duty_q;
      compare_value_o   <= recip_prod[dsd_pkg::RECIP_SHIFT +: 16];
      digit_valid_o     <= s2_tick_q;
      digit_index_o     <= s2_tick_q ? s2_pos_q : 2'd0;
      segment_pattern_o <= s2_tick_q ? pattern : 8'h00;
    end
  end

  assign out_valid_o = s3_v_q;

endmodule

`default_nettype wire

// File: tb/sv/tb_duty_setpoint_seven_segment_display_core.sv
// Self-checking testbench of the duty setpoint and seven-segment display core.
`default_nettype none

module tb_duty_setpoint_seven_segment_display_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned REPORT_MAX = 10;
  // Segment font, digit d in bits [8*d +: 8]
  localparam logic [79:0] FONT = {8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D,
                                  8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F};

  // One result beat, field by field
  typedef struct packed {
    logic [6:0]  duty;
    logic [15:0] cmp;
    logic        dv;
    logic [1:0]  idx;
    logic [7:0]  seg;
  } duty_beat_t;

  // Directed stimulus row; want is used only when typed is set
  typedef struct packed {
    dsd_pkg::cmd_e cmd;
    logic [7:0]    amount;
    logic [9:0]    sample;
    logic          typed;
    duty_beat_t    want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i = dsd_pkg::CMD_TICK;
  logic [7:0]  step_amount_i = 8'd0;
  logic [9:0]  adc_sample_i = 10'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [6:0]  duty_percent_o;
  logic [15:0] compare_value_o;
  logic        digit_valid_o;
  logic [1:0]  digit_index_o;
  logic [7:0]  segment_pattern_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = dsd_pkg::ADDR_PWM_TOP;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  duty_setpoint_seven_segment_display_core uut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .cmd_i, .step_amount_i, .adc_sample_i,
    .out_valid_o, .out_stall_i, .duty_percent_o, .compare_value_o,
    .digit_valid_o, .digit_index_o, .segment_pattern_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Predicted block state
  logic [15:0] top_q;
  logic [9:0]  blank_q;
  logic [6:0]  duty_q;
  logic [7:0]  glyph_q [0:2];
  logic [1:0]  scan_q;
  logic [9:0]  idle_q;

  duty_beat_t  pending_beats [$];
  dir_row_t    dir_table [$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endfunction

  // Write a value as three digits with leading blanks, optional dot on the left
  function automatic void draw_value(input int unsigned v, input bit dot);
    glyph_q[0] = (v < 100) ? 8'h00 : FONT[8*((v / 100) % 10) +: 8];
    glyph_q[1] = (v < 10) ? 8'h00 : FONT[8*((v / 10) % 10) +: 8];
    glyph_q[2] = FONT[8*(v % 10) +: 8];
    if (dot) begin
      glyph_q[0] = glyph_q[0] | dsd_pkg::DOT_BIT;
    end
  endfunction

  // Advance the predicted state by one command and return its result beat
  function automatic duty_beat_t advance_setpoint(input dsd_pkg::cmd_e c,
                                                  input logic [7:0] amt,
                                                  input logic [9:0] smp);
    duty_beat_t  r;
    int unsigned sum;
    r = '0;
    case (c)
      dsd_pkg::CMD_INC: begin
        sum = duty_q + amt;
        duty_q = (sum > dsd_pkg::DUTY_MAX) ? 7'd1 : sum[6:0];
        idle_q = '0;
        draw_value(duty_q, 1'b0);
      end
      dsd_pkg::CMD_DEC: begin
        if (amt == duty_q) duty_q = dsd_pkg::DUTY_MAX;
        else if (amt > duty_q) duty_q = 7'd1;
        else duty_q = duty_q - amt[6:0];
        idle_q = '0;
        draw_value(duty_q, 1'b0);
      end
      dsd_pkg::CMD_ADC: begin
        draw_value((smp * 500) / 1024, 1'b1);
        idle_q = '0;
      end
      default: begin
        if (scan_q >= dsd_pkg::DIGIT_COUNT) scan_q = '0;
        r.dv = 1'b1;
        r.idx = scan_q;
        r.seg = glyph_q[scan_q];
        scan_q = (scan_q + 1 >= dsd_pkg::DIGIT_COUNT) ? 2'd0 : scan_q + 2'd1;
        // blanking takes effect from the next tick on
        if (idle_q >= blank_q) begin
          glyph_q[0] = '0;
          glyph_q[1] = '0;
          glyph_q[2] = '0;
        end else begin
          idle_q = idle_q + 10'd1;
        end
      end
    endcase
    r.duty = duty_q;
    r.cmp = 16'((int'(duty_q) * int'(top_q)) / 100);
    return r;
  endfunction

  function automatic dir_row_t row(input dsd_pkg::cmd_e c, input int a, input int s,
                                   input bit t, input int d, input int cv, input int v,
                                   input int i, input int g);
    dir_row_t x;
    x.cmd = c;
    x.amount = a[7:0];
    x.sample = s[9:0];
    x.typed = t;
    x.want = {d[6:0], cv[15:0], v[0], i[1:0], g[7:0]};
    return x;
  endfunction

  // Send one input beat after a random gap; predict when it is accepted
  task automatic send_item(input dsd_pkg::cmd_e c, input logic [7:0] amt,
                           input logic [9:0] smp, input bit typed, input duty_beat_t want);
    duty_beat_t p;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= c;
    step_amount_i <= amt;
    adc_sample_i <= smp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    p = advance_setpoint(c, amt, smp);
    pending_beats.push_back(typed ? want : p);
  endtask

  task automatic drain_results;
    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
  endtask

  // Register access: setup phase, then access phase until pready, then an idle phase
  task automatic reg_access(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reg_check(input logic [2:0] addr, input logic [31:0] want);
    logic [31:0] got;
    reg_access(1'b0, addr, '0, got);
    if (got !== want) begin
      note_failure($sformatf("reg read addr %0d: expected %0d got %0d", addr, want, got));
    end
  endtask

  // Write both registers with junk in the unused bits, then read them back
  task automatic set_registers(input logic [15:0] top, input logic [9:0] blank);
    logic [31:0] dummy;
    reg_access(1'b1, dsd_pkg::ADDR_PWM_TOP, {16'($urandom_range(65535, 0)), top}, dummy);
    top_q = top;
    reg_access(1'b1, dsd_pkg::ADDR_BLANK_TICKS, {22'($urandom_range(4194303, 0)), blank},
               dummy);
    blank_q = blank;
    reg_check(dsd_pkg::ADDR_PWM_TOP, {16'd0, top});
    reg_check(dsd_pkg::ADDR_BLANK_TICKS, {22'd0, blank});
  endtask

  // Random phase: ticks most often, mostly small steps, some exact-to-zero decrements
  task automatic run_phase(input logic [15:0] top, input logic [9:0] blank,
                           input int unsigned s_pct, input int unsigned r_pct,
                           input int unsigned count, input int unsigned hold_at);
    int unsigned   k, pick;
    dsd_pkg::cmd_e c;
    logic [7:0]    amt;
    set_registers(top, blank);
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    for (k = 0; k < count; k++) begin
      if (hold_at != 0 && k == hold_at) drain_results();
      pick = $urandom_range(99, 0);
      c = (pick < 40) ? dsd_pkg::CMD_TICK : (pick < 60) ? dsd_pkg::CMD_INC :
          (pick < 80) ? dsd_pkg::CMD_DEC : dsd_pkg::CMD_ADC;
      pick = $urandom_range(99, 0);
      if (pick < 10) amt = 8'd0;
      else if (pick < 20) amt = {1'b0, duty_q};
      else if (pick < 65) amt = 8'($urandom_range(30, 0));
      else amt = 8'($urandom_range(255, 0));
      send_item(c, amt, 10'($urandom_range(1023, 0)), 1'b0, '0);
    end
    drain_results();
  endtask

  // Result beat checker and receiver stall
  always @(posedge clk_i) begin : result_check
    duty_beat_t got, want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {duty_percent_o, compare_value_o, digit_valid_o, digit_index_o,
               segment_pattern_o};
        if (pending_beats.size() == 0) begin
          note_failure($sformatf("unexpected beat duty=%0d cmp=%0d dv=%0d idx=%0d seg=%h",
                                 got.duty, got.cmp, got.dv, got.idx, got.seg));
        end else begin
          want = pending_beats.pop_front();
          if (got.duty !== want.duty || got.cmp !== want.cmp || got.dv !== want.dv ||
              got.idx !== want.idx || got.seg !== want.seg) begin
            note_failure($sformatf({"beat mismatch: expected duty=%0d cmp=%0d dv=%0d ",
                                    "idx=%0d seg=%h, got duty=%0d cmp=%0d dv=%0d ",
                                    "idx=%0d seg=%h"},
                                   want.duty, want.cmp, want.dv, want.idx, want.seg,
                                   got.duty, got.cmp, got.dv, got.idx, got.seg));
          end
        end
      end
      out_stall_i <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("duty_setpoint_seven_segment_display_core regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned n;
    // predictor reset state
    top_q = dsd_pkg::TOP_RESET;
    blank_q = dsd_pkg::BLANK_RESET;
    duty_q = dsd_pkg::DUTY_RESET;
    glyph_q[0] = '0;
    glyph_q[1] = '0;
    glyph_q[2] = '0;
    scan_q = '0;
    idle_q = '0;

    // Directed rows: extremes, wraps, small values, dot on blank digit
    dir_table.push_back(row(dsd_pkg::CMD_TICK, 0, 0, 1, 50, 624, 1, 0, 8'h00));
    dir_table.push_back(row(dsd_pkg::CMD_INC, 0, 0, 1, 50, 624, 0, 0, 0));
    dir_table.push_back(row(dsd_pkg::CMD_TICK, 0, 0, 1, 50, 624, 1, 1, 8'h6D));
    dir_table.push_back(row(dsd_pkg::CMD_TICK, 0, 0, 1, 50, 624, 1, 2, 8'h3F));
    dir_table.push_back(row(dsd_pkg::CMD_INC, 50, 0, 1, 100, 1249, 0, 0, 0));
    dir_table.push_back(row(dsd_pkg::CMD_TICK, 0, 0, 1, 100, 1249, 1, 0, 8'h06));
    dir_table.push_back(row(dsd_pkg::CMD_INC, 1, 0, 1, 1, 12, 0, 0, 0));
    dir_table.push_back(row(dsd_pkg::CMD_TICK, 0, 0, 1, 1, 12, 1, 1, 8'h00));
    dir_table.push_back(row(dsd_pkg::CMD_TICK, 0, 0, 1, 1, 12, 1, 2, 8'h06));
    dir_table.push_back(row(dsd_pkg::CMD_DEC, 1, 0, 1, 100, 1249, 0, 0, 0));
    dir_table.push_back(row(dsd_pkg::CMD_DEC, 255, 1023, 1, 1, 12, 0, 0, 0));
    dir_table.push_back(row(dsd_pkg::CMD_INC, 255, 1023, 1, 1, 12, 0, 0, 0));
    dir_table.push_back(row(dsd_pkg::CMD_INC, 8, 0, 0, 0, 0, 0, 0, 0));
    dir_table.push_back(row(dsd_pkg::CMD_DEC, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_table.push_back(row(dsd_pkg::CMD_ADC, 255, 0, 0, 0, 0, 0, 0, 0));
    dir_table.push_back(row(dsd_pkg::CMD_TICK, 0, 0, 1, 9, 112, 1, 0, 8'h80));
    dir_table.push_back(row(dsd_pkg::CMD_ADC, 0, 1023, 0, 0, 0, 0, 0, 0));
    dir_table.push_back(row(dsd_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_table.push_back(row(dsd_pkg::CMD_ADC, 0, 21, 0, 0, 0, 0, 0, 0));
    dir_table.push_back(row(dsd_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_table.push_back(row(dsd_pkg::CMD_TICK, 0, 0, 1, 9, 112, 1, 0, 8'h80));
    dir_table.push_back(row(dsd_pkg::CMD_ADC, 0, 20, 0, 0, 0, 0, 0, 0));
    dir_table.push_back(row(dsd_pkg::CMD_INC, 91, 0, 1, 100, 1249, 0, 0, 0));
    dir_table.push_back(row(dsd_pkg::CMD_TICK, 0, 0, 1, 100, 1249, 1, 1, 8'h3F));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers come up at their defaults
    reg_check(dsd_pkg::ADDR_PWM_TOP, {16'd0, dsd_pkg::TOP_RESET});
    reg_check(dsd_pkg::ADDR_BLANK_TICKS, {22'd0, dsd_pkg::BLANK_RESET});

    send_idle_pct = 30;
    recv_stall_pct = 68;
    for (n = 0; n < dir_table.size(); n++) begin
      send_item(dir_table[n].cmd, dir_table[n].amount, dir_table[n].sample,
                dir_table[n].typed, dir_table[n].want);
    end
    drain_results();

    // random phases: receiver stalls most, then sender idles most, then neither
    run_phase(16'd65535, 10'd0, 30, 68, 90, 0);
    run_phase(16'd1, 10'd3, 30, 68, 80, 0);
    run_phase(16'd0, 10'd1023, 68, 30, 80, 0);
    run_phase(16'd1000, 10'd1, 68, 30, 80, 0);
    run_phase(16'($urandom_range(65535, 1)), 10'd7, 0, 0, 90, 40);
    run_phase(16'd1249, 10'd2, 0, 0, 80, 0);

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_beats.size() == 0) begin
      $display("duty_setpoint_seven_segment_display_core regression: pass");
    end else begin
      $display("duty_setpoint_seven_segment_display_core regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
